// ===== rtl/tarc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag access relay controller package
// Shared widths, command codes and register indexes.
// ----------------------------------------------------------------------------
package tarc_pkg;

   localparam int TAG_BYTES  = 5;
   localparam int CARD_COUNT = 3;
   localparam int CARD_REGS  = 3;

   localparam int TAG_W   = 40;
   localparam int CNT_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   localparam int CMP_W     = (TAG_BYTES * 8 < TAG_W) ? TAG_BYTES * 8 : TAG_W;
   localparam int CARD_USED = (CARD_COUNT < CARD_REGS) ? CARD_COUNT : CARD_REGS;

   localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(30000);
   localparam logic [CNT_W-1:0] PULSE_RESET  = CNT_W'(500);
   localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

   typedef enum logic [REQ_TUSER_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_CARD   = 2'd1,
      CMD_BUTTON = 2'd2
   } command_type;

   localparam logic [CSR_IDX_W-1:0] REG_CARD_ZERO   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CARD_ONE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CARD_TWO    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AUTH_WINDOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_LEN   = 3'd4;

   localparam int RSP_RELAY_BIT   = 0;
   localparam int RSP_LAMP_BIT    = 1;
   localparam int RSP_AUTH_BIT    = 2;
   localparam int RSP_MATCHED_BIT = 3;

endpackage

// ===== rtl/tag_access_relay_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag access relay controller core
// Card tag check with an authorization window and a timed relay pulse.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_tvalid/req_tready  tuser command, tdata card tag
//   rsp      out        rsp_tvalid/rsp_tready  tdata relay, lamp, auth, match
//   csr      in         csr_valid/csr_ready    register index and write data
//
// A request is registered, evaluated combinationally and its response registered,
// so it passes the input register and then the response register, and one request
// is taken every cycle while the response is not stalled.
// Reset restores the register defaults and clears the mode, counters and
// pipeline. A stalled response holds the pipeline; csr writes are always taken.
// ----------------------------------------------------------------------------
module tag_access_relay_controller_core
   import tarc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [39:0] card_tag
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [0] relay_on, [1] lamp_on,
                                              // [2] authorized, [3] card_matched
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TAG_W-1:0]       csr_data
);

   logic [TAG_W-1:0] card_ff [CARD_REGS];
   logic [CNT_W-1:0] window_len_ff;
   logic [CNT_W-1:0] pulse_len_ff;

   logic              in_valid_ff;
   command_type       in_cmd_ff;
   logic [TAG_W-1:0]  in_tag_ff;

   logic              mode_ff, mode_in;
   logic [CNT_W-1:0]  window_ff, window_in;
   logic [CNT_W-1:0]  pulse_ff, pulse_in;
   logic              relay_ff, relay_in;
   logic              lamp_ff, lamp_in;
   logic              matched_in;

   logic              rsp_valid_ff;
   logic              rsp_relay_ff, rsp_lamp_ff, rsp_auth_ff, rsp_matched_ff;

   logic              advance;
   logic              take;
   logic              tag_hit;
   logic              run_check;
   logic              button;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign take       = advance && in_valid_ff;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CARD_REGS; i++) begin
            card_ff[i] <= '0;
         end
         window_len_ff <= WINDOW_RESET;
         pulse_len_ff  <= PULSE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CARD_ZERO:   card_ff[0]    <= csr_data;
            REG_CARD_ONE:    card_ff[1]    <= csr_data;
            REG_CARD_TWO:    card_ff[2]    <= csr_data;
            REG_AUTH_WINDOW: window_len_ff <= csr_data[CNT_W-1:0];
            REG_PULSE_LEN:   pulse_len_ff  <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      tag_hit = 1'b0;
      for (int i = 0; i < CARD_USED; i++) begin
         if (card_ff[i][CMP_W-1:0] == in_tag_ff[CMP_W-1:0]) begin
            tag_hit = 1'b1;
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      window_in  = window_ff;
      pulse_in   = pulse_ff;
      relay_in   = relay_ff;
      lamp_in    = lamp_ff;
      matched_in = 1'b0;
      run_check  = 1'b0;
      button     = 1'b0;
      case (in_cmd_ff)
         CMD_TICK: begin
            if (mode_ff) begin
               window_in = (window_ff == CNT_MAX) ? window_ff : window_ff + 1'b1;
               pulse_in  = (pulse_ff == CNT_MAX) ? pulse_ff : pulse_ff + 1'b1;
               run_check = 1'b1;
            end
         end
         CMD_CARD: begin
            if (!mode_ff) begin
               if (tag_hit) begin
                  matched_in = 1'b1;
                  mode_in    = 1'b1;
                  lamp_in    = 1'b1;
                  relay_in   = 1'b1;
                  window_in  = '0;
                  pulse_in   = '0;
               end
            end else begin
               run_check = 1'b1;
            end
         end
         CMD_BUTTON: begin
            run_check = mode_ff;
            button    = 1'b1;
         end
         default: ;
      endcase
      if (run_check) begin
         if (window_in >= window_len_ff) begin
            mode_in  = 1'b0;
            relay_in = 1'b0;
            lamp_in  = 1'b0;
         end else if (button) begin
            pulse_in = '0;
            relay_in = 1'b1;
         end
         if (pulse_in >= pulse_len_ff) begin
            relay_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         window_ff    <= '0;
         pulse_ff     <= '0;
         relay_ff     <= 1'b0;
         lamp_ff      <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (take) begin
            mode_ff   <= mode_in;
            window_ff <= window_in;
            pulse_ff  <= pulse_in;
            relay_ff  <= relay_in;
            lamp_ff   <= lamp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= command_type'(req_tuser);
         in_tag_ff <= req_tdata;
      end
      if (take) begin
         rsp_relay_ff   <= relay_in;
         rsp_lamp_ff    <= lamp_in;
         rsp_auth_ff    <= mode_in;
         rsp_matched_ff <= matched_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[RSP_RELAY_BIT]   = rsp_relay_ff;
      rsp_tdata[RSP_LAMP_BIT]    = rsp_lamp_ff;
      rsp_tdata[RSP_AUTH_BIT]    = rsp_auth_ff;
      rsp_tdata[RSP_MATCHED_BIT] = rsp_matched_ff;
   end

endmodule

// ===== rtl/tarc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag access relay controller checker
// Port-level properties of the controller core, bound into the core module.
// ----------------------------------------------------------------------------
module tarc_checker
   import tarc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Response valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_MATCHED_BIT] |->
         rsp_tdata[RSP_AUTH_BIT] && rsp_tdata[RSP_LAMP_BIT] && rsp_tdata[RSP_RELAY_BIT])
      else $error("Matched card without authorization, lamp and relay.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_AUTH_BIT] |->
         !rsp_tdata[RSP_LAMP_BIT] && !rsp_tdata[RSP_RELAY_BIT])
      else $error("Lamp or relay on while waiting.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_AUTH_BIT] |-> rsp_tdata[RSP_LAMP_BIT])
      else $error("Lamp off while authorized.");

endmodule

bind tag_access_relay_controller_core tarc_checker u_tarc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
